// ===== src/ttoi_pkg.sv =====
// shared types and constants for the text to integer parser
package ttoi_pkg;

  localparam int unsigned MaxCount = 255;
  localparam int unsigned CountW   = $clog2(MaxCount + 1);
  localparam int unsigned ValueW   = 64;
  localparam int unsigned ChW      = 8;
  localparam int unsigned RadixW   = 5;
  localparam int unsigned ShownW   = 8;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned ProdW    = ValueW + RadixW;

  localparam logic [RadixW-1:0] RadixReset = RadixW'(10);
  localparam logic [RadixW-1:0] BaseAuto   = RadixW'(0);
  localparam logic [RadixW-1:0] BaseOct    = RadixW'(8);
  localparam logic [RadixW-1:0] BaseDec    = RadixW'(10);
  localparam logic [RadixW-1:0] BaseHex    = RadixW'(16);

  localparam logic [ChW-1:0] ChSpace  = 8'd32;
  localparam logic [ChW-1:0] ChTab    = 8'd9;
  localparam logic [ChW-1:0] ChCr     = 8'd13;
  localparam logic [ChW-1:0] ChPlus   = 8'd43;
  localparam logic [ChW-1:0] ChMinus  = 8'd45;
  localparam logic [ChW-1:0] ChZero   = 8'd48;
  localparam logic [ChW-1:0] ChNine   = 8'd57;
  localparam logic [ChW-1:0] ChUpA    = 8'd65;
  localparam logic [ChW-1:0] ChUpF    = 8'd70;
  localparam logic [ChW-1:0] ChLowA   = 8'd97;
  localparam logic [ChW-1:0] ChLowF   = 8'd102;
  localparam logic [ChW-1:0] ChUpX    = 8'd88;
  localparam logic [ChW-1:0] ChLowX   = 8'd120;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS
  } ttoi_phase_e;

  typedef struct packed {
    logic              blank;
    logic              plus;
    logic              minus;
    logic              zero;
    logic              ex;
    logic              dig_ok;
    logic [DigitW-1:0] dig;
  } ttoi_class_t;

  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
    logic [ShownW-1:0]        consumed;
    logic                     overflowed;
  } ttoi_res_t;

endpackage

// ===== src/ttoi_in_if.sv =====
// character input channel
interface ttoi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;
  logic       last;

  modport source (output valid, ch, first, last, input ready);
  modport sink (input valid, ch, first, last, output ready);
endinterface

// ===== src/ttoi_out_if.sv =====
// parsed result output channel
interface ttoi_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [7:0]         consumed;
  logic               overflowed;

  modport source (output valid, value, consumed, overflowed, input ready);
  modport sink (input valid, value, consumed, overflowed, output ready);
endinterface

// ===== src/ttoi_decode.sv =====
// character classification: whitespace, sign, prefix and digit value
module ttoi_decode
  import ttoi_pkg::*;
(
  input  logic [ChW-1:0] ch_i,
  output ttoi_class_t    cls_o
);

  always_comb begin
    cls_o        = '0;
    cls_o.blank  = (ch_i == ChSpace) || (ch_i >= ChTab && ch_i <= ChCr);
    cls_o.plus   = (ch_i == ChPlus);
    cls_o.minus  = (ch_i == ChMinus);
    cls_o.zero   = (ch_i == ChZero);
    cls_o.ex     = (ch_i == ChLowX) || (ch_i == ChUpX);
    if (ch_i >= ChZero && ch_i <= ChNine) begin
      cls_o.dig_ok = 1'b1;
      cls_o.dig    = DigitW'(ch_i - ChZero);
    end else if (ch_i >= ChLowA && ch_i <= ChLowF) begin
      cls_o.dig_ok = 1'b1;
      cls_o.dig    = DigitW'(ch_i - ChLowA + 8'd10);
    end else if (ch_i >= ChUpA && ch_i <= ChUpF) begin
      cls_o.dig_ok = 1'b1;
      cls_o.dig    = DigitW'(ch_i - ChUpA + 8'd10);
    end
  end

endmodule

// ===== src/ttoi_core.sv =====
// parse state registers and the per-character update with multiply-add
module ttoi_core
  import ttoi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [ChW-1:0]    ch_i,
  input  logic              first_i,
  input  logic              last_i,
  input  logic [RadixW-1:0] radix_i,
  output ttoi_res_t         res_o
);

  ttoi_class_t cls;

  ttoi_phase_e         phase_q, phase_d;
  logic                neg_q, neg_d;
  logic [ValueW-1:0]   mag_q, mag_d;
  logic [RadixW-1:0]   base_q, base_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                wrap_q, wrap_d;
  logic                done_q, done_d;
  logic                emit;

  ttoi_decode u_decode (
    .ch_i  (ch_i),
    .cls_o (cls)
  );

  // next state
  always_comb begin
    logic             take;
    logic             reject;
    logic [ProdW-1:0] prod;
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    base_d  = base_q;
    count_d = count_q;
    wrap_d  = wrap_q;
    done_d  = done_q;
    emit    = 1'b0;
    take    = 1'b1;
    reject  = 1'b0;
    prod    = '0;
    if (fire_i && (first_i || !done_q)) begin
      if (first_i) begin
        phase_d = PH_SPACE;
        neg_d   = 1'b0;
        mag_d   = '0;
        base_d  = radix_i;
        count_d = '0;
        wrap_d  = 1'b0;
        done_d  = 1'b0;
      end
      if (phase_d == PH_SPACE) begin
        if (cls.blank) begin
          take = 1'b0;
        end else if (cls.plus || cls.minus) begin
          neg_d   = cls.minus;
          phase_d = PH_PREFIX;
          take    = 1'b0;
        end else begin
          phase_d = PH_PREFIX;
        end
      end
      if (take && phase_d == PH_PREFIX) begin
        if (cls.zero && (base_d == BaseAuto || base_d == BaseHex)) begin
          phase_d = PH_ZERO;
          take    = 1'b0;
        end else begin
          if (base_d == BaseAuto) base_d = BaseDec;
          phase_d = PH_DIGITS;
        end
      end
      if (take && phase_d == PH_ZERO) begin
        if (cls.ex) begin
          base_d  = BaseHex;
          phase_d = PH_DIGITS;
          take    = 1'b0;
        end else begin
          if (base_d == BaseAuto) base_d = BaseOct;
          phase_d = PH_DIGITS;
        end
      end
      if (take && phase_d == PH_DIGITS) begin
        if (!cls.dig_ok || base_d == BaseAuto || RadixW'(cls.dig) >= base_d) begin
          reject = 1'b1;
        end else begin
          prod  = ProdW'(mag_d) * ProdW'(base_d) + ProdW'(cls.dig);
          mag_d = prod[ValueW-1:0];
          if (|prod[ProdW-1:ValueW]) wrap_d = 1'b1;
        end
      end
      // every step but a rejected digit consumes the character
      if (!reject && count_d < CountW'(MaxCount)) count_d = count_d + 1'b1;
      if (reject || last_i) begin
        emit   = 1'b1;
        done_d = 1'b1;
      end
    end
  end

  // result
  always_comb begin
    res_o.valid      = emit;
    res_o.value      = neg_d ? -$signed(mag_d) : $signed(mag_d);
    res_o.consumed   = (32'(count_d) > 32'd255) ? ShownW'(255) : ShownW'(count_d);
    res_o.overflowed = wrap_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      base_q  <= '0;
      count_q <= '0;
      wrap_q  <= 1'b0;
      done_q  <= 1'b1;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      base_q  <= base_d;
      count_q <= count_d;
      wrap_q  <= wrap_d;
      done_q  <= done_d;
    end
  end

endmodule

// ===== src/text_to_integer_parser.sv =====
// top level of the streaming text to integer parser
// Takes one character per transaction and accepts a new one every cycle while
// results are taken; a result shows on the output after the transaction that
// ends its string (the character lands in the input register at the accepting
// edge, and the parse update loads the result register once the output is
// free). The sustained rate of one character per cycle is set by the loop
// through the parse state, whose longest path is the 64 by 5 bit multiply-add
// of the magnitude. The radix register is sampled when a character marked
// first is parsed; a string yields one result, at the first rejected character
// or at the character marked last.
module text_to_integer_parser
  import ttoi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RadixW-1:0] cfg_wdata_i,
  ttoi_in_if.sink           char_i,
  ttoi_out_if.source        res_o
);

  logic [RadixW-1:0] radix_val_q;
  logic              in_valid_q;
  logic [ChW-1:0]    ch_q;
  logic              first_q;
  logic              last_q;
  logic              out_valid_q;
  logic signed [ValueW-1:0] value_q;
  logic [ShownW-1:0] consumed_q;
  logic              overflowed_q;
  logic              out_free;
  logic              fire;
  ttoi_res_t         res;

  assign out_free     = !out_valid_q || res_o.ready;
  assign fire         = in_valid_q && out_free;
  assign char_i.ready = !in_valid_q || fire;

  ttoi_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .ch_i    (ch_q),
    .first_i (first_q),
    .last_i  (last_q),
    .radix_i (radix_val_q),
    .res_o   (res)
  );

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_val_q <= RadixReset;
    end else if (cfg_we_i) begin
      radix_val_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      ch_q    <= char_i.ch;
      first_q <= char_i.first;
      last_q  <= char_i.last;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      value_q      <= res.value;
      consumed_q   <= res.consumed;
      overflowed_q <= res.overflowed;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.value      = value_q;
  assign res_o.consumed   = consumed_q;
  assign res_o.overflowed = overflowed_q;

endmodule

// ===== tb/tb_text_to_integer_parser.sv =====
// self-checking testbench for the streaming text to integer parser
module tb_text_to_integer_parser;
  import ttoi_pkg::*;

  localparam int unsigned        CycleLimit  = 400000;
  localparam int unsigned        HoldCycles  = 300;
  localparam int unsigned        PhaseItems  = 75;
  localparam logic [RadixW-1:0]  NotDigit    = RadixW'(16);
  localparam logic [RadixW-1:0]  RadixOne    = RadixW'(1);
  localparam logic [RadixW-1:0]  RadixBin    = RadixW'(2);
  localparam logic [RadixW-1:0]  RadixLow17  = RadixW'(17);
  localparam logic [RadixW-1:0]  RadixTop    = RadixW'(31);

  class strtol_scoreboard;
    logic [RadixW-1:0] radix_q;
    ttoi_phase_e       stage;
    bit                neg;
    logic [ValueW-1:0] mag;
    logic [RadixW-1:0] base;
    int unsigned       count;
    bit                wrapped;
    bit                done;
    ttoi_res_t         pending_parses[$];
    int unsigned       errors;

    function new();
      radix_q = RadixReset;
      stage   = PH_SPACE;
      neg     = 1'b0;
      mag     = '0;
      base    = BaseAuto;
      count   = 0;
      wrapped = 1'b0;
      done    = 1'b1;
      errors  = 0;
    endfunction

    function void set_radix(logic [RadixW-1:0] r);
      radix_q = r;
    endfunction

    function void bump();
      if (count < MaxCount) count++;
    endfunction

    function logic [RadixW-1:0] digit_val(logic [ChW-1:0] c);
      if (c >= ChZero && c <= ChNine) return RadixW'(c - ChZero);
      if (c >= ChLowA && c <= ChLowF) return RadixW'(c - ChLowA + 10);
      if (c >= ChUpA && c <= ChUpF) return RadixW'(c - ChUpA + 10);
      return NotDigit;
    endfunction

    // returns 1 when the character was not ignored
    function bit parse_char(logic [ChW-1:0] c, bit is_first, bit is_last);
      bit               take;
      bit               reject;
      logic [RadixW-1:0] d;
      logic [ProdW-1:0] prod;
      ttoi_res_t        res;
      take   = 1'b1;
      reject = 1'b0;
      if (is_first) begin
        stage   = PH_SPACE;
        neg     = 1'b0;
        mag     = '0;
        base    = radix_q;
        count   = 0;
        wrapped = 1'b0;
        done    = 1'b0;
      end else if (done) begin
        return 1'b0;
      end
      if (stage == PH_SPACE) begin
        if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
          bump();
          take = 1'b0;
        end else if (c == ChPlus || c == ChMinus) begin
          neg = (c == ChMinus);
          bump();
          stage = PH_PREFIX;
          take = 1'b0;
        end else begin
          stage = PH_PREFIX;
        end
      end
      if (take && stage == PH_PREFIX) begin
        if (c == ChZero && (base == BaseAuto || base == BaseHex)) begin
          bump();
          stage = PH_ZERO;
          take = 1'b0;
        end else begin
          if (base == BaseAuto) base = BaseDec;
          stage = PH_DIGITS;
        end
      end
      if (take && stage == PH_ZERO) begin
        if (c == ChLowX || c == ChUpX) begin
          base = BaseHex;
          bump();
          stage = PH_DIGITS;
          take = 1'b0;
        end else begin
          if (base == BaseAuto) base = BaseOct;
          stage = PH_DIGITS;
        end
      end
      if (take && stage == PH_DIGITS) begin
        d = digit_val(c);
        if (d == NotDigit || base == BaseAuto || d >= base) begin
          reject = 1'b1;
        end else begin
          prod = ProdW'(mag) * ProdW'(base) + ProdW'(d);
          if (prod[ProdW-1:ValueW] != '0) wrapped = 1'b1;
          mag = prod[ValueW-1:0];
          bump();
        end
      end
      if (reject || is_last) begin
        res.valid      = 1'b1;
        res.value      = neg ? (ValueW'(0) - mag) : mag;
        res.consumed   = (count > 255) ? ShownW'(255) : ShownW'(count);
        res.overflowed = wrapped;
        pending_parses.push_back(res);
        done = 1'b1;
      end
      return 1'b1;
    endfunction

    function void note_err(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_parse(logic signed [ValueW-1:0] v, logic [ShownW-1:0] c, logic o);
      ttoi_res_t exp_res;
      if (pending_parses.size() == 0) begin
        note_err($sformatf("unexpected result: value %0d consumed %0d overflowed %0b",
                           v, c, o));
        return;
      end
      exp_res = pending_parses.pop_front();
      if (exp_res.value !== v)
        note_err($sformatf("value: expected %0d, got %0d", exp_res.value, v));
      if (exp_res.consumed !== c)
        note_err($sformatf("consumed: expected %0d, got %0d", exp_res.consumed, c));
      if (exp_res.overflowed !== o)
        note_err($sformatf("overflowed: expected %0b, got %0b", exp_res.overflowed, o));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [RadixW-1:0] cfg_wdata;
  int unsigned       cycles;
  int unsigned       burst_left;
  int unsigned       taken;
  bit                hold_req;
  strtol_scoreboard  sb;

  ttoi_in_if  char_if ();
  ttoi_out_if res_if ();

  text_to_integer_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .char_i      (char_if),
    .res_o       (res_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_text_to_integer_parser: done, errors");
      $finish;
    end
  end

  // result side with its own stall pattern and one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    mode_left = 0;
    hold_left = 0;
    mode = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready)
        sb.check_parse(res_if.value, res_if.consumed, res_if.overflowed);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_char(logic [ChW-1:0] c, bit is_first, bit is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        char_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    char_if.valid <= 1'b1;
    char_if.ch    <= c;
    char_if.first <= is_first;
    char_if.last  <= is_last;
    do @(posedge clk_i); while (!char_if.ready);
    if (sb.parse_char(c, is_first, is_last)) taken++;
  endtask

  task automatic drain();
    char_if.valid <= 1'b0;
    while (sb.pending_parses.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_radix(logic [RadixW-1:0] r);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_radix(r);
  endtask

  function automatic logic [ChW-1:0] digit_char(int unsigned d);
    if (d < 10) return ChZero + ChW'(d);
    return ($urandom_range(0, 1) ? ChLowA : ChUpA) + ChW'(d - 10);
  endfunction

  task automatic send_number(logic [RadixW-1:0] r, int unsigned lead);
    logic [ChW-1:0] s[$];
    int unsigned    gb;
    int unsigned    pick;
    int unsigned    nd;
    int unsigned    end_kind;
    int unsigned    k;
    bit             mark_last;
    s = {};
    repeat (lead) begin
      k = $urandom_range(0, 5);
      s.push_back((k == 5) ? ChSpace : ChTab + ChW'(k));
    end
    case ($urandom_range(0, 3))
      0: s.push_back(ChMinus);
      1: s.push_back(ChPlus);
      default: ;
    endcase
    pick = $urandom_range(0, 3);
    if ((r == BaseAuto || r == BaseHex) && pick == 0) begin
      s.push_back(ChZero);
      s.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
      gb = 16;
    end else if (r == BaseAuto && pick == 1) begin
      s.push_back(ChZero);
      gb = 8;
    end else if (r == BaseAuto) begin
      gb = 10;
    end else begin
      gb = 32'(r);
    end
    if (gb > 16) gb = 16;
    nd = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 26) : $urandom_range(0, 8);
    repeat (nd) s.push_back(digit_char($urandom_range(0, gb - 1)));
    end_kind = $urandom_range(0, 5);
    mark_last = (end_kind <= 2) || (end_kind == 4);
    if (end_kind == 3) begin
      s.push_back($urandom_range(0, 1) ? 8'h00 : ChW'($urandom_range(0, 255)));
      mark_last = 1'($urandom_range(0, 1));
    end else if (end_kind == 4) begin
      s.push_back(ChW'($urandom_range(0, 255)));
    end
    if (s.size() == 0) s.push_back(ChZero);
    foreach (s[i]) send_char(s[i], i == 0, mark_last && (i == s.size() - 1));
  endtask

  initial begin
    logic [RadixW-1:0] radix_plan[9];
    bit                held;
    sb = new();
    radix_plan = '{BaseAuto, BaseDec, BaseHex, RadixBin, BaseOct, RadixOne,
                   RadixTop, RadixLow17, BaseDec};
    radix_plan[8] = RadixW'($urandom_range(0, 31));
    burst_left = 0;
    taken = 0;
    held = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    char_if.valid = 1'b0;
    char_if.ch = '0;
    char_if.first = 1'b0;
    char_if.last = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, default radix
    send_char(ChZero + 8'd5, 1'b0, 1'b0);
    send_char(ChSpace, 1'b1, 1'b0);
    send_char(ChMinus, 1'b0, 1'b0);
    send_char(ChZero + 8'd1, 1'b0, 1'b0);
    send_char(ChZero + 8'd2, 1'b0, 1'b1);
    send_char(ChZero + 8'd7, 1'b1, 1'b0);
    send_char(ChPlus, 1'b1, 1'b0);
    send_char(ChNine, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(ChZero + 8'd3, 1'b1, 1'b0);
    send_char(ChLowA, 1'b0, 1'b1);
    // automatic base: bare hex prefix, lone zero going octal
    write_radix(BaseAuto);
    send_char(ChZero, 1'b1, 1'b0);
    send_char(ChLowX, 1'b0, 1'b0);
    send_char(8'h00, 1'b0, 1'b1);
    send_char(ChZero, 1'b1, 1'b0);
    send_char(ChZero + 8'd7, 1'b0, 1'b0);
    send_char(ChZero + 8'd8, 1'b0, 1'b0);
    write_radix(BaseHex);
    send_char(ChZero, 1'b1, 1'b0);
    send_char(ChUpX, 1'b0, 1'b0);
    send_char(ChLowF, 1'b0, 1'b0);
    send_char(ChUpF, 1'b0, 1'b1);
    write_radix(RadixOne);
    send_char(ChZero, 1'b1, 1'b0);
    send_char(ChZero + 8'd1, 1'b0, 1'b1);
    write_radix(RadixTop);
    send_char(ChUpF, 1'b1, 1'b1);

    foreach (radix_plan[p]) begin
      write_radix(radix_plan[p]);
      taken = 0;
      if (p == 1) send_number(radix_plan[p], $urandom_range(250, 300));
      while (taken < PhaseItems) begin
        if (p == 2 && !held && taken > PhaseItems / 3) begin
          held = 1'b1;
          hold_req = 1'b1;
        end
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3))
            send_char(ChW'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                      1'($urandom_range(0, 1)));
        else
          send_number(radix_plan[p], ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      end
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_parses.size() == 0) begin
      $display("tb_text_to_integer_parser: done, clean");
    end else begin
      $display("tb_text_to_integer_parser: done, errors");
    end
    $finish;
  end

endmodule

// ===== text_to_integer_parser.f =====
src/ttoi_pkg.sv
src/ttoi_in_if.sv
src/ttoi_out_if.sv
src/ttoi_decode.sv
src/ttoi_core.sv
src/text_to_integer_parser.sv
tb/tb_text_to_integer_parser.sv
